FILE: hdl/urhb_pkg.sv
// Shared types and constants for the undo/redo history buffer.
`default_nettype none

package urhb_pkg;

	localparam int ADDR_W  = 16;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 5;

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_UNDO  = 2'd1;
	localparam logic [1:0] CMD_REDO  = 2'd2;
	localparam logic [1:0] CMD_CLEAR = 2'd3;

	localparam logic [COUNT_W-1:0] MAX_DEPTH_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [ADDR_W-1:0]  target_address;
		logic [VALUE_W-1:0] current_value;
		logic [VALUE_W-1:0] new_value;
	} in_item_t;

	typedef struct packed {
		logic               write_enable;
		logic [ADDR_W-1:0]  write_address;
		logic [VALUE_W-1:0] write_value;
		logic               accepted;
		logic               changed;
		logic               can_undo;
		logic               can_redo;
		logic [COUNT_W-1:0] entry_count;
		logic [COUNT_W-1:0] cursor_position;
	} out_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		logic [VALUE_W-1:0] old_value;
		logic [VALUE_W-1:0] new_value;
	} entry_t;

endpackage

`default_nettype wire

FILE: hdl/urhb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module urhb_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: hdl/undo_redo_history_buffer.sv
// Top level of the bounded undo/redo write journal.
//
// Usage: the command channel (in_valid / in_stall / in_data) takes one
// transaction per command: push, undo, redo or clear. Every command yields
// exactly one result transaction on out_valid / out_stall / out_data, which
// carries the write to perform (push and redo emit the new value, undo the
// old one) plus the journal status after the command.
// Pipeline: two register stages. The accept edge loads the read stage, which
// passes on to the output register when that is free or drains. Throughput:
// one command per cycle while out_stall is low; the journal pointers update
// at the accept edge and the entry RAM is read or written in that same edge,
// so its registered read port adds the read stage. Backpressure: a finished
// result waits in the output register while one more command is taken into
// the read stage; further commands are stalled until the receiver takes the
// waiting result. Reset: the journal empties (count, cursor and oldest slot
// go to zero) and max_depth returns to 16. Entry storage is not cleared; only
// live entries are ever read. cfg_write_en / cfg_write_data set max_depth;
// the user must write it only while idle, as the block does not enforce it.
`default_nettype none

module undo_redo_history_buffer #(
	parameter int HISTORY_DEPTH = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire urhb_pkg::in_item_t                   in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output urhb_pkg::out_item_t                       out_data,
	input  wire logic                                 cfg_write_en,
	input  wire logic [urhb_pkg::COUNT_W-1:0]         cfg_write_data
);

	localparam int SW    = $clog2(HISTORY_DEPTH);
	localparam int SUM_W = ((SW > urhb_pkg::COUNT_W) ? SW : urhb_pkg::COUNT_W) + 2;
	localparam int CAP   = (HISTORY_DEPTH < 31) ? HISTORY_DEPTH : 31;
	localparam logic [urhb_pkg::COUNT_W-1:0] CAP_C   = urhb_pkg::COUNT_W'(CAP);
	localparam logic [SUM_W-1:0]             DEPTH_S = SUM_W'(HISTORY_DEPTH);
	localparam int ENTRY_W = $bits(urhb_pkg::entry_t);

	// Source of the emitted write in the read stage.
	localparam logic [1:0] SRC_HELD = 2'd0;
	localparam logic [1:0] SRC_OLD  = 2'd1;
	localparam logic [1:0] SRC_NEW  = 2'd2;

	// Wrap a logical offset from the oldest slot into the circular store.
	function automatic logic [SW-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
		if (sum >= DEPTH_S) begin
			return SW'(sum - DEPTH_S);
		end
		return SW'(sum);
	endfunction

	// Journal pointers and configuration.
	logic [SW-1:0]                oldest_q;
	logic [urhb_pkg::COUNT_W-1:0] held_q;
	logic [urhb_pkg::COUNT_W-1:0] cursor_q;
	logic [urhb_pkg::COUNT_W-1:0] max_depth_q;

	// Read stage.
	logic                valid_s1;
	logic [1:0]          src_s1;
	urhb_pkg::out_item_t res_s1;

	// Output register.
	logic                out_valid_q;
	urhb_pkg::out_item_t out_q;

	logic                         accept;
	logic                         adv_s1;
	logic [urhb_pkg::COUNT_W-1:0] eff_depth;
	logic [urhb_pkg::COUNT_W:0]   held_new;
	logic [urhb_pkg::COUNT_W:0]   excess;
	logic [SW-1:0]                slot_cur;
	logic [SW-1:0]                rd_slot;
	logic [SW-1:0]                nxt_oldest;
	logic [urhb_pkg::COUNT_W-1:0] nxt_held;
	logic [urhb_pkg::COUNT_W-1:0] nxt_cursor;
	logic                         wr_en;
	logic                         rd_en;
	logic [1:0]                   nxt_src;
	urhb_pkg::out_item_t          nxt_res;
	urhb_pkg::out_item_t          merged_res;
	urhb_pkg::entry_t             wr_entry;
	urhb_pkg::entry_t             rd_entry;
	logic [ENTRY_W-1:0]           rd_raw;

	// Advance the read stage whenever the output register is free or drains.
	assign adv_s1   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	// Clamp max_depth into 1 .. HISTORY_DEPTH, and to at most 31.
	always_comb begin
		if (max_depth_q == '0) begin
			eff_depth = urhb_pkg::COUNT_W'(1);
		end else if (max_depth_q > CAP_C) begin
			eff_depth = CAP_C;
		end else begin
			eff_depth = max_depth_q;
		end
	end

	assign slot_cur = wrap_slot(SUM_W'(oldest_q) + SUM_W'(cursor_q));
	assign held_new = {1'b0, cursor_q} + 1'b1;
	assign excess   = held_new - {1'b0, eff_depth};

	assign wr_entry.address   = in_data.target_address;
	assign wr_entry.old_value = in_data.current_value;
	assign wr_entry.new_value = in_data.new_value;

	// Next pointers, RAM access and the status part of the result.
	always_comb begin
		nxt_oldest = oldest_q;
		nxt_held   = held_q;
		nxt_cursor = cursor_q;
		wr_en      = 1'b0;
		rd_en      = 1'b0;
		rd_slot    = slot_cur;
		nxt_src    = SRC_HELD;
		nxt_res    = '0;
		unique case (in_data.cmd)
			urhb_pkg::CMD_PUSH: begin
				// Overwrite the slot at the cursor; everything above is dropped.
				wr_en = accept;
				if (held_new > {1'b0, eff_depth}) begin
					nxt_oldest = wrap_slot(SUM_W'(oldest_q) + SUM_W'(excess));
					nxt_held   = eff_depth;
					nxt_cursor = eff_depth;
				end else begin
					nxt_held   = held_new[urhb_pkg::COUNT_W-1:0];
					nxt_cursor = held_new[urhb_pkg::COUNT_W-1:0];
				end
				nxt_res.write_enable  = 1'b1;
				nxt_res.write_address = in_data.target_address;
				nxt_res.write_value   = in_data.new_value;
				nxt_res.accepted      = 1'b1;
				nxt_res.changed       = 1'b1;
			end
			urhb_pkg::CMD_UNDO: begin
				if (cursor_q != '0) begin
					nxt_cursor = cursor_q - 1'b1;
					rd_slot    = wrap_slot(SUM_W'(oldest_q) + SUM_W'(cursor_q - 1'b1));
					rd_en      = accept;
					nxt_src    = SRC_OLD;
					nxt_res.write_enable = 1'b1;
					nxt_res.accepted     = 1'b1;
					nxt_res.changed      = 1'b1;
				end
			end
			urhb_pkg::CMD_REDO: begin
				if (cursor_q < held_q) begin
					nxt_cursor = cursor_q + 1'b1;
					rd_en      = accept;
					nxt_src    = SRC_NEW;
					nxt_res.write_enable = 1'b1;
					nxt_res.accepted     = 1'b1;
					nxt_res.changed      = 1'b1;
				end
			end
			urhb_pkg::CMD_CLEAR: begin
				nxt_oldest = '0;
				nxt_held   = '0;
				nxt_cursor = '0;
				nxt_res.accepted = 1'b1;
				nxt_res.changed  = 1'b1;
			end
		endcase
		nxt_res.can_undo        = (nxt_cursor != '0);
		nxt_res.can_redo        = (nxt_cursor < nxt_held);
		nxt_res.entry_count     = nxt_held;
		nxt_res.cursor_position = nxt_cursor;
	end

	// Entry store: write on push, read on a granted undo or redo.
	urhb_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(HISTORY_DEPTH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (slot_cur),
		.wr_data (wr_entry),
		.rd_en   (rd_en),
		.rd_addr (rd_slot),
		.rd_data (rd_raw)
	);

	assign rd_entry = urhb_pkg::entry_t'(rd_raw);

	// Pointers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q    <= '0;
			held_q      <= '0;
			cursor_q    <= '0;
			max_depth_q <= urhb_pkg::MAX_DEPTH_RESET;
		end else begin
			if (accept) begin
				oldest_q <= nxt_oldest;
				held_q   <= nxt_held;
				cursor_q <= nxt_cursor;
			end
			if (cfg_write_en) begin
				max_depth_q <= cfg_write_data;
			end
		end
	end

	// Read stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Read stage payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1 <= nxt_src;
			res_s1 <= nxt_res;
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Merge the entry read back from RAM into the result.
	always_comb begin
		merged_res = res_s1;
		unique case (src_s1)
			SRC_OLD: begin
				merged_res.write_address = rd_entry.address;
				merged_res.write_value   = rd_entry.old_value;
			end
			SRC_NEW: begin
				merged_res.write_address = rd_entry.address;
				merged_res.write_value   = rd_entry.new_value;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_q <= merged_res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

FILE: bench/urhb_journal_checker.sv
// Checker for the undo/redo history buffer: predicts each result and compares it.
`timescale 1ns / 100ps

module urhb_journal_checker
	import urhb_pkg::*;
#(
	parameter int JOURNAL_SLOTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  in_item_t            in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  out_item_t           out_data,
	input  logic                cfg_write_en,
	input  logic [COUNT_W-1:0]  cfg_write_data,
	output int                  mismatch_count,
	output int                  results_checked,
	output int                  results_pending
);

	entry_t             journal [JOURNAL_SLOTS];
	int                 oldest_slot;
	int                 held;
	int                 cursor;
	logic [COUNT_W-1:0] max_depth;

	out_item_t          expected_results [$];
	out_item_t          predicted;
	out_item_t          want;

	// Advance the journal by one command and build the result it yields.
	task automatic journal_apply(input in_item_t c, output out_item_t r);
		int depth;
		int excess;
		int s;
		r = '0;
		depth = (max_depth == 0) ? 1 : (max_depth > JOURNAL_SLOTS) ? JOURNAL_SLOTS : max_depth;
		case (c.cmd)
			CMD_PUSH: begin
				s = (oldest_slot + cursor) % JOURNAL_SLOTS;
				journal[s] = entry_t'{c.target_address, c.current_value, c.new_value};
				held = cursor + 1;
				cursor = held;
				// drop every excess oldest entry at once, also after a lowered depth
				if (held > depth) begin
					excess = held - depth;
					oldest_slot = (oldest_slot + excess) % JOURNAL_SLOTS;
					held = depth;
					cursor = cursor - excess;
				end
				r.write_enable = 1'b1;
				r.write_address = c.target_address;
				r.write_value = c.new_value;
				r.accepted = 1'b1;
				r.changed = 1'b1;
			end
			CMD_UNDO: begin
				if (cursor > 0) begin
					cursor = cursor - 1;
					s = (oldest_slot + cursor) % JOURNAL_SLOTS;
					r.write_enable = 1'b1;
					r.write_address = journal[s].address;
					r.write_value = journal[s].old_value;
					r.accepted = 1'b1;
					r.changed = 1'b1;
				end
			end
			CMD_REDO: begin
				if (cursor < held) begin
					s = (oldest_slot + cursor) % JOURNAL_SLOTS;
					r.write_enable = 1'b1;
					r.write_address = journal[s].address;
					r.write_value = journal[s].new_value;
					cursor = cursor + 1;
					r.accepted = 1'b1;
					r.changed = 1'b1;
				end
			end
			default: begin
				held = 0;
				cursor = 0;
				oldest_slot = 0;
				r.accepted = 1'b1;
				r.changed = 1'b1;
			end
		endcase
		r.can_undo = (cursor > 0);
		r.can_redo = (cursor < held);
		r.entry_count = COUNT_W'(held);
		r.cursor_position = COUNT_W'(cursor);
	endtask

	function automatic string result_text(input out_item_t r);
		return $sformatf("we=%b addr=%h val=%h acc=%b chg=%b undo=%b redo=%b cnt=%0d cur=%0d",
			r.write_enable, r.write_address, r.write_value, r.accepted, r.changed,
			r.can_undo, r.can_redo, r.entry_count, r.cursor_position);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_slot = 0;
			held = 0;
			cursor = 0;
			max_depth = MAX_DEPTH_RESET;
			expected_results.delete();
			mismatch_count = 0;
			results_checked = 0;
			results_pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("%0t: result with none expected: %s", $time, result_text(out_data));
				end else begin
					want = expected_results.pop_front();
					results_checked++;
					if (out_data.write_enable !== want.write_enable ||
					    out_data.write_address !== want.write_address ||
					    out_data.write_value !== want.write_value ||
					    out_data.accepted !== want.accepted ||
					    out_data.changed !== want.changed ||
					    out_data.can_undo !== want.can_undo ||
					    out_data.can_redo !== want.can_redo ||
					    out_data.entry_count !== want.entry_count ||
					    out_data.cursor_position !== want.cursor_position) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("%0t: result %0d mismatch", $time, results_checked);
							$display("  expected %s", result_text(want));
							$display("  actual   %s", result_text(out_data));
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				journal_apply(in_data, predicted);
				expected_results = {expected_results, predicted};
			end
			if (cfg_write_en)
				max_depth = cfg_write_data;
			results_pending = expected_results.size();
		end
	end

endmodule

FILE: bench/tb_undo_redo_history_buffer.sv
// Testbench top for the undo/redo history buffer: stimulus, depth settings and verdict.
`timescale 1ns / 100ps

module tb_undo_redo_history_buffer;
	import urhb_pkg::*;

	localparam int SLOTS           = 16;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 8;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_item_t          out_data;
	logic               cfg_write_en;
	logic [COUNT_W-1:0] cfg_write_data;

	int mismatch_count;
	int results_checked;
	int results_pending;

	// Per phase: max_depth written, sender idle and receiver stall percentages,
	// and the number of random commands. Depths 0, 31 and 17 fall outside the
	// legal range and must clamp.
	int phase_depth [PHASES] = '{16, 3, 0, 31, 1, 17, 7, 16};
	int phase_idle  [PHASES] = '{ 0, 59, 0, 33, 0, 59, 0, 33};
	int phase_stall [PHASES] = '{ 0, 0, 59, 33, 0, 0, 59, 33};
	int phase_items [PHASES] = '{70, 55, 45, 65, 30, 45, 45, 65};

	int sender_idle_pct;
	int recv_stall_pct;
	int holdoff_requests;
	int holdoff_served;
	int holdoff_left;
	int cycle_count;
	int push_count, undo_count, redo_count, clear_count;

	always #4 clk = ~clk;

	undo_redo_history_buffer #(
		.HISTORY_DEPTH(SLOTS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_data      (out_data),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data)
	);

	urhb_journal_checker #(
		.JOURNAL_SLOTS(SLOTS)
	) journal_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.mismatch_count (mismatch_count),
		.results_checked(results_checked),
		.results_pending(results_pending)
	);

	// Receiver: stall at random, except during a requested hold-off, when it
	// holds stall high for a fixed stretch so the journal backs up and stalls
	// its command input.
	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			out_stall <= 1'b1;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_served != holdoff_requests) begin
			out_stall <= 1'b1;
			holdoff_served <= holdoff_served + 1;
			holdoff_left <= HOLD_OFF_CYCLES - 1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// Watchdog: end the run if the results never drain.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results still expected",
				cycle_count, results_pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one command and hold it until it is taken. Entered and left at a
	// falling edge; idle gaps before the transaction drop valid, never between
	// a stalled offer and its acceptance.
	task automatic send_command(input in_item_t c);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= c;
		case (c.cmd)
			CMD_PUSH: push_count++;
			CMD_UNDO: undo_count++;
			CMD_REDO: redo_count++;
			default:  clear_count++;
		endcase
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// Weighted mix: pushes lead so the journal fills, undo and redo walk the
	// cursor, clear now and then. Addresses sometimes sit at the extremes.
	function automatic in_item_t random_command();
		in_item_t c;
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 46)
			c.cmd = CMD_PUSH;
		else if (roll < 72)
			c.cmd = CMD_UNDO;
		else if (roll < 94)
			c.cmd = CMD_REDO;
		else
			c.cmd = CMD_CLEAR;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			c.target_address = '0;
		else if (roll == 1)
			c.target_address = '1;
		else
			c.target_address = ADDR_W'($urandom_range(0, 65535));
		c.current_value = $urandom;
		c.new_value = $urandom;
		return c;
	endfunction

	initial begin
		int p;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_write_en = 1'b0;
		cfg_write_data = '0;
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		holdoff_requests = 0;
		holdoff_served = 0;
		holdoff_left = 0;
		cycle_count = 0;
		push_count = 0;
		undo_count = 0;
		redo_count = 0;
		clear_count = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed pass at the reset depth: refusals on an empty journal,
		// clear on an empty journal, extreme field values, undo and redo to
		// both ends, and a push that discards the redo side.
		send_command(in_item_t'{CMD_UNDO, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_command(in_item_t'{CMD_REDO, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_command(in_item_t'{CMD_CLEAR, 16'h0000, 32'h0, 32'h0});
		send_command(in_item_t'{CMD_PUSH, 16'h0000, 32'h0000_0000, 32'h0000_0000});
		send_command(in_item_t'{CMD_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_command(in_item_t'{CMD_PUSH, 16'h1234, 32'hA5A5_A5A5, 32'h5A5A_5A5A});
		repeat (4)
			send_command(in_item_t'{CMD_UNDO, 16'h0, 32'h0, 32'h0});
		repeat (4)
			send_command(in_item_t'{CMD_REDO, 16'h0, 32'h0, 32'h0});
		send_command(in_item_t'{CMD_UNDO, 16'h0, 32'h0, 32'h0});
		send_command(in_item_t'{CMD_UNDO, 16'h0, 32'h0, 32'h0});
		send_command(in_item_t'{CMD_PUSH, 16'h8001, 32'h0F0F_0F0F, 32'hF0F0_F0F0});
		send_command(in_item_t'{CMD_REDO, 16'h0, 32'h0, 32'h0});
		send_command(in_item_t'{CMD_UNDO, 16'h0, 32'h0, 32'h0});
		send_command(in_item_t'{CMD_REDO, 16'h0, 32'h0, 32'h0});
		send_command(in_item_t'{CMD_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
		send_command(in_item_t'{CMD_UNDO, 16'h0, 32'h0, 32'h0});

		for (p = 0; p < PHASES; p++) begin
			// Drain every outstanding result before touching max_depth.
			in_valid <= 1'b0;
			@(negedge clk);
			while (results_pending != 0)
				@(negedge clk);
			cfg_write_en <= 1'b1;
			cfg_write_data <= COUNT_W'(phase_depth[p]);
			@(negedge clk);
			cfg_write_en <= 1'b0;
			sender_idle_pct = phase_idle[p];
			recv_stall_pct <= phase_stall[p];

			for (n = 0; n < phase_items[p]; n++) begin
				if (p == 0 && n == 25)
					holdoff_requests <= holdoff_requests + 1;
				send_command(random_command());
			end

			// Fill the journal to its full depth and past it, so the next
			// phase lowers max_depth under a full journal; undo and redo then
			// still reach the surplus entries until the next push trims them.
			if (p == 0) begin
				repeat (SLOTS + 2) begin
					send_command(in_item_t'{CMD_PUSH, ADDR_W'($urandom_range(0, 65535)),
						32'($urandom), 32'($urandom)});
				end
				repeat (3)
					send_command(in_item_t'{CMD_UNDO, 16'h0, 32'h0, 32'h0});
			end
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (results_pending != 0)
			@(negedge clk);
		// Keep the clock running a little longer so a stray late result is still caught.
		repeat (8) @(negedge clk);

		$display("Ran %0d commands (%0d push, %0d undo, %0d redo, %0d clear), %0d results checked",
			push_count + undo_count + redo_count + clear_count,
			push_count, undo_count, redo_count, clear_count, results_checked);
		$display("Depths 0 to 31 incl. clamped ones, four idle patterns and one long output hold-off");
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatching results", mismatch_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
hdl/urhb_pkg.sv
hdl/urhb_ram.sv
hdl/undo_redo_history_buffer.sv
bench/urhb_journal_checker.sv
bench/tb_undo_redo_history_buffer.sv
